// File: rtl/core/rnpf_pkg.sv
// rnpf_pkg: shared types, constants and codes for the radius neighbor and pair finder
// no dependencies; imported by rnpf_dist, the top level, the checker and the bench
`default_nettype none

package rnpf_pkg;

  // default sizes of the point table and coordinates
  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF = 16;

  // fixed field widths on the stream ports
  localparam int FIELD_W    = 16;
  localparam int ROW_W      = 6;
  localparam int MASK_W     = 64;
  localparam int CNT_W      = 7;
  localparam int IN_DATA_W  = 3 * FIELD_W;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 80;
  localparam int OUT_USER_W = 1;

  // tag carried with each compare through the distance pipeline
  localparam int TAG_W = 6;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_QUERY = 2'd2,
    OP_SCAN  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  // compare request into the distance pipeline
  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
  } dist_req_t;

  // compare result out of the distance pipeline
  typedef struct packed {
    logic             valid;
    logic             hit;
    logic [TAG_W-1:0] tag;
  } dist_res_t;

endpackage

`default_nettype wire

// File: rtl/core/rnpf_cell.sv
// rnpf_cell: one storage cell of the point ring, holds one x/y position
// depends on nothing but the clock; chained by the top level into a ring
`default_nettype none

module rnpf_cell #(
  parameter int COORD_W = 16
) (
  input  wire logic               clk,
  input  wire logic               shift,
  input  wire logic               ld,
  input  wire logic [COORD_W-1:0] ld_x,
  input  wire logic [COORD_W-1:0] ld_y,
  input  wire logic [COORD_W-1:0] nb_x,
  input  wire logic [COORD_W-1:0] nb_y,
  output logic      [COORD_W-1:0] x,
  output logic      [COORD_W-1:0] y
);

  // load a new point, or take the neighbor's point while the ring turns
  always_ff @(posedge clk) begin
    if (ld) begin
      x <= ld_x;
      y <= ld_y;
    end else if (shift) begin
      x <= nb_x;
      y <= nb_y;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/rnpf_dist.sv
// rnpf_dist: pipelined squared distance and radius compare, two register stages
// depends on rnpf_pkg for the request and result structs
`default_nettype none

module rnpf_dist #(
  parameter int COORD_W = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic [COORD_W-1:0]     ax,
  input  wire logic [COORD_W-1:0]     ay,
  input  wire logic [COORD_W-1:0]     bx,
  input  wire logic [COORD_W-1:0]     by,
  input  wire logic [2*COORD_W-1:0]   r2,
  input  wire logic                   strict,
  input  wire rnpf_pkg::dist_req_t    req,
  output rnpf_pkg::dist_res_t         res,
  output logic                        busy
);
  import rnpf_pkg::*;

  localparam int SQ_W = 2 * COORD_W;

  logic [COORD_W-1:0] dx, dy;
  dist_req_t          s1;
  logic [SQ_W-1:0]    sqx, sqy;
  dist_req_t          s2;
  logic [SQ_W:0]      sum;
  logic               hit;

  // stage 1: absolute differences
  always_ff @(posedge clk) begin
    dx <= (ax >= bx) ? (ax - bx) : (bx - ax);
    dy <= (ay >= by) ? (ay - by) : (by - ay);
  end

  // stage 2: squares
  always_ff @(posedge clk) begin
    sqx <= SQ_W'(dx) * SQ_W'(dx);
    sqy <= SQ_W'(dy) * SQ_W'(dy);
  end

  // valid and tag travel alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
      s2 <= '0;
    end else begin
      s1 <= req;
      s2 <= s1;
    end
  end

  // sum of squares against radius squared, strict for pair scans
  always_comb begin
    sum = {1'b0, sqx} + {1'b0, sqy};
    hit = strict ? (sum < {1'b0, r2}) : (sum <= {1'b0, r2});
  end

  assign res.valid = s2.valid;
  assign res.hit   = hit;
  assign res.tag   = s2.tag;
  assign busy      = s1.valid | s2.valid;

endmodule

`default_nettype wire

// File: rtl/core/radius_neighbor_and_pair_finder.sv
// radius_neighbor_and_pair_finder: point table as a ring of cells with one shared
// distance pipeline; depends on rnpf_pkg, rnpf_cell and rnpf_dist
//
//  channel  dir  tdata (low bit up)                 tuser       tlast
//  s_*      in   pos_x, pos_y, radius               op          -
//  m_*      out  row_index, hit_mask, hit_count, 0  status      last
//
// load and clear: no ring pass; the result is registered from the emit state
// a circle query turns the ring once, drains the distance pipeline and emits;
// a pair scan does all of that for each of its n rows
// reset clears the point count and the control state; table contents stay as they are
// a stalled output holds the engine at its next result; input is taken only when idle
`default_nettype none

module radius_neighbor_and_pair_finder #(
  parameter int MAX_POINTS = rnpf_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = rnpf_pkg::COORD_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // pos_x [15:0], pos_y [31:16], radius [47:32]
  input  wire logic [rnpf_pkg::IN_DATA_W-1:0]  s_tdata,
  // op [1:0]
  input  wire logic [rnpf_pkg::IN_USER_W-1:0]  s_tuser,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // row_index [5:0], hit_mask [69:6], hit_count [76:70], zero [79:77]
  output logic [rnpf_pkg::OUT_DATA_W-1:0]      m_tdata,
  // status [0]
  output logic [rnpf_pkg::OUT_USER_W-1:0]      m_tuser,
  output logic                                 m_tlast
);
  import rnpf_pkg::*;

  localparam int CW   = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
  localparam int IW   = $clog2(MAX_POINTS);
  localparam int NW   = $clog2(MAX_POINTS + 1);

  state_t            state, state_next;
  op_t               op_q;
  logic [NW-1:0]     n;
  logic [IW-1:0]     row;
  logic [IW-1:0]     c;
  logic [CW-1:0]     ref_x, ref_y;
  logic [2*CW-1:0]   r2;
  logic [MAX_POINTS-1:0] mask;
  logic [NW-1:0]     cnt;
  logic              status_q;

  logic              acc, out_free, start_pass, do_emit, ld_en, next_row, last_now;
  logic [CW-1:0]     in_x, in_y, in_rad;
  op_t               in_op;
  logic [CW-1:0]     cx [MAX_POINTS];
  logic [CW-1:0]     cy [MAX_POINTS];
  dist_req_t         req;
  dist_res_t         res;
  logic              dist_busy;
  logic [MASK_W-1:0] mask_ext;

  // input fields, cut to the coordinate width
  assign in_x   = s_tdata[CW-1:0];
  assign in_y   = s_tdata[FIELD_W +: CW];
  assign in_rad = s_tdata[2*FIELD_W +: CW];
  assign in_op  = op_t'(s_tuser[1:0]);

  assign s_tready = (state == ST_IDLE);
  assign acc      = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign ld_en    = acc && (in_op == OP_LOAD) && (n != NW'(MAX_POINTS));
  assign last_now = (op_q != OP_SCAN) || ((NW'(row) + NW'(1)) == n);

  // ring of point cells, each takes its upper neighbor while turning
  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
    rnpf_cell #(.COORD_W(CW)) u_cell (
      .clk   (clk),
      .shift (state == ST_RUN),
      .ld    (ld_en && (n == NW'(k))),
      .ld_x  (in_x),
      .ld_y  (in_y),
      .nb_x  (cx[(k + 1) % MAX_POINTS]),
      .nb_y  (cy[(k + 1) % MAX_POINTS]),
      .x     (cx[k]),
      .y     (cy[k])
    );
  end

  // compare request for the point now at the head of the ring
  always_comb begin
    req.valid = (state == ST_RUN) && (NW'(c) < n) && ((op_q == OP_QUERY) || (c > row));
    req.tag   = TAG_W'(c);
  end

  rnpf_dist #(.COORD_W(CW)) u_dist (
    .clk    (clk),
    .rst    (rst),
    .ax     (cx[0]),
    .ay     (cy[0]),
    .bx     (ref_x),
    .by     (ref_y),
    .r2     (r2),
    .strict (op_q == OP_SCAN),
    .req    (req),
    .res    (res),
    .busy   (dist_busy)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and control strobes
  always_comb begin
    state_next = state;
    start_pass = 1'b0;
    do_emit    = 1'b0;
    next_row   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (acc) begin
          case (in_op)
            OP_LOAD, OP_CLEAR: state_next = ST_EMIT;
            OP_QUERY: begin
              start_pass = 1'b1;
              state_next = ST_RUN;
            end
            OP_SCAN: begin
              if (n != '0) begin
                start_pass = 1'b1;
                state_next = ST_RUN;
              end
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_RUN: begin
        if (c == IW'(MAX_POINTS - 1)) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!dist_busy) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          do_emit = 1'b1;
          if (!last_now) begin
            next_row   = 1'b1;
            start_pass = 1'b1;
            state_next = ST_RUN;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // point count
  always_ff @(posedge clk) begin
    if (rst) begin
      n <= '0;
    end else if (acc && (in_op == OP_CLEAR)) begin
      n <= '0;
    end else if (ld_en) begin
      n <= n + NW'(1);
    end
  end

  // operation registers, reference point and row counter
  always_ff @(posedge clk) begin
    if (acc) begin
      op_q     <= in_op;
      r2       <= (2*CW)'(in_rad) * (2*CW)'(in_rad);
      ref_x    <= in_x;
      ref_y    <= in_y;
      row      <= '0;
      status_q <= (in_op == OP_LOAD) && (n == NW'(MAX_POINTS));
    end else begin
      if (next_row) row <= row + IW'(1);
      // pair scan: the row's own point becomes the reference as it passes the head
      if ((state == ST_RUN) && (op_q == OP_SCAN) && (c == row)) begin
        ref_x <= cx[0];
        ref_y <= cy[0];
      end
    end
  end

  // turn counter
  always_ff @(posedge clk) begin
    if (start_pass) begin
      c <= '0;
    end else if (state == ST_RUN) begin
      c <= c + IW'(1);
    end
  end

  // hit mask and count, built one compare at a time
  always_ff @(posedge clk) begin
    if (acc || start_pass) begin
      mask <= '0;
      cnt  <= '0;
    end else if (res.valid && res.hit) begin
      for (int k = 0; k < MAX_POINTS; k++) begin
        if (res.tag == TAG_W'(k)) mask[k] <= 1'b1;
      end
      cnt <= cnt + NW'(1);
    end
  end

  always_comb begin
    mask_ext                 = '0;
    mask_ext[MAX_POINTS-1:0] = mask;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (do_emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_emit) begin
      m_tdata <= {(OUT_DATA_W - ROW_W - MASK_W - CNT_W)'(0), CNT_W'(cnt), mask_ext,
                  ROW_W'(row)};
      m_tuser <= OUT_USER_W'(status_q);
      m_tlast <= last_now;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/rnpf_checker.sv
// rnpf_checker: port-level checks for radius_neighbor_and_pair_finder, bound to the top
// depends on rnpf_pkg for the port field layout
`default_nettype none

module rnpf_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            s_tvalid,
  input wire logic                            s_tready,
  input wire logic [rnpf_pkg::IN_USER_W-1:0]  s_tuser,
  input wire logic                            m_tvalid,
  input wire logic                            m_tready,
  input wire logic [rnpf_pkg::OUT_DATA_W-1:0] m_tdata,
  input wire logic [rnpf_pkg::OUT_USER_W-1:0] m_tuser,
  input wire logic                            m_tlast
);
  import rnpf_pkg::*;

  logic [MASK_W-1:0] out_mask;
  logic [CNT_W-1:0]  out_cnt;

  assign out_mask = m_tdata[ROW_W +: MASK_W];
  assign out_cnt  = m_tdata[ROW_W + MASK_W +: CNT_W];

  // count always matches the mask it travels with
  a_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($countones(out_mask) == 32'(out_cnt)))
    else $error("hit_count does not match hit_mask");

  // a rejected load is a single, empty result
  a_reject: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tlast && (out_mask == '0) && (out_cnt == '0)))
    else $error("rejected load carries data or is not last");

  // only pair scan rows are not last, and those never flag a full table
  a_row: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (m_tuser[0] == 1'b0))
    else $error("non-last result carries table-full status");

  // a stalled transfer holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("output changed while stalled");

  // any input but a pair scan takes the engine out of idle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser != IN_USER_W'(OP_SCAN))) |=> !s_tready)
    else $error("input still ready right after a transfer");

endmodule

bind radius_neighbor_and_pair_finder rnpf_checker u_rnpf_checker (.*);

`default_nettype wire

// File: verif/radius_neighbor_and_pair_finder_tb.sv
// radius_neighbor_and_pair_finder_tb: self-checking bench for the point table, circle query
// and pair scan; drives the stream ports and checks results against a built-in predictor
// depends on rnpf_pkg and radius_neighbor_and_pair_finder
`timescale 1ns / 100ps

module radius_neighbor_and_pair_finder_tb;
  import rnpf_pkg::*;

  localparam int TABLE_DEPTH  = 64;
  localparam int ITEM_TARGET  = 500;
  localparam int PHASE2_AT    = 170;
  localparam int PHASE3_AT    = 340;
  localparam int FULL_AT      = 230;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 2 * (TABLE_DEPTH + 3);
  localparam int N_DIRECTED   = 23;

  // one result transfer as seen on the master side
  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [MASK_W-1:0] mask;
    logic [CNT_W-1:0]  cnt;
    logic              status;
    logic              last;
  } hit_result_t;

  // directed stimulus row; typed rows carry their single result
  typedef struct packed {
    op_t               op;
    logic [15:0]       x;
    logic [15:0]       y;
    logic [15:0]       r;
    logic              typed;
    logic [MASK_W-1:0] mask;
    logic [CNT_W-1:0]  cnt;
    logic              status;
  } stim_row_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata;
  logic [IN_USER_W-1:0] s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;
  logic m_tlast;

  // predictor state: copy of the point table
  logic [15:0] tbl_x [TABLE_DEPTH];
  logic [15:0] tbl_y [TABLE_DEPTH];
  int          tbl_n;

  hit_result_t expected_hits [$];
  int items_sent;
  int results_seen;
  int loads_refused;
  int scan_rows;
  int failures;
  int src_gap_pct;
  int sink_gap_pct;
  int idle_cycles;
  int hold_left;
  bit hold_req;

  stim_row_t directed_rows [N_DIRECTED] = '{
    '{OP_QUERY, 16'h0000, 16'h0000, 16'h0000, 1'b1, 64'h0,  7'd0, 1'b0},
    '{OP_SCAN,  16'h0000, 16'h0000, 16'hFFFF, 1'b0, 64'h0,  7'd0, 1'b0},
    '{OP_CLEAR, 16'h0000, 16'h0000, 16'h0000, 1'b1, 64'h0,  7'd0, 1'b0},
    '{OP_LOAD,  16'h0000, 16'h0000, 16'h0000, 1'b1, 64'h0,  7'd0, 1'b0},
    '{OP_LOAD,  16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 64'h0,  7'd0, 1'b0},
    '{OP_LOAD,  16'h0010, 16'h0000, 16'h0000, 1'b1, 64'h0,  7'd0, 1'b0},
    '{OP_LOAD,  16'h0000, 16'h0010, 16'h0000, 1'b1, 64'h0,  7'd0, 1'b0},
    '{OP_LOAD,  16'hFFFF, 16'h0000, 16'h0000, 1'b1, 64'h0,  7'd0, 1'b0},
    // zero radius still hits the point on the centre
    '{OP_QUERY, 16'h0000, 16'h0000, 16'h0000, 1'b1, 64'h1,  7'd1, 1'b0},
    // points exactly on the circle count
    '{OP_QUERY, 16'h0000, 16'h0000, 16'h0010, 1'b1, 64'hD,  7'd3, 1'b0},
    '{OP_QUERY, 16'h0000, 16'h0000, 16'hFFFF, 1'b1, 64'h1D, 7'd4, 1'b0},
    // pair scans: zero radius, boundary radius (strict), just above, maximum
    '{OP_SCAN,  16'h0000, 16'h0000, 16'h0000, 1'b0, 64'h0,  7'd0, 1'b0},
    '{OP_SCAN,  16'h0000, 16'h0000, 16'h0010, 1'b0, 64'h0,  7'd0, 1'b0},
    '{OP_SCAN,  16'h0000, 16'h0000, 16'h0011, 1'b0, 64'h0,  7'd0, 1'b0},
    '{OP_SCAN,  16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 64'h0,  7'd0, 1'b0},
    '{OP_QUERY, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 64'h0,  7'd0, 1'b0},
    '{OP_QUERY, 16'h8000, 16'h8000, 16'hFFFF, 1'b0, 64'h0,  7'd0, 1'b0},
    '{OP_QUERY, 16'hAAAA, 16'h5555, 16'h5555, 1'b0, 64'h0,  7'd0, 1'b0},
    '{OP_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 64'h0,  7'd0, 1'b0},
    // scan on an empty table gives nothing
    '{OP_SCAN,  16'h0000, 16'h0000, 16'h0100, 1'b0, 64'h0,  7'd0, 1'b0},
    '{OP_LOAD,  16'h1234, 16'h4321, 16'h0000, 1'b1, 64'h0,  7'd0, 1'b0},
    '{OP_QUERY, 16'h1234, 16'h4321, 16'h0000, 1'b1, 64'h1,  7'd1, 1'b0},
    '{OP_CLEAR, 16'h0000, 16'h0000, 16'h0000, 1'b1, 64'h0,  7'd0, 1'b0}
  };

  radius_neighbor_and_pair_finder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // exact squared distance as an unsigned integer, Q33.0
  function automatic longint unsigned sq_dist(logic [15:0] ax, ay, bx, by);
    longint unsigned dx;
    longint unsigned dy;
    dx = (ax >= bx) ? longint'(ax - bx) : longint'(bx - ax);
    dy = (ay >= by) ? longint'(ay - by) : longint'(by - ay);
    return dx * dx + dy * dy;
  endfunction

  // append one result to the expected queue
  function automatic void queue_result(hit_result_t res);
    expected_hits = {expected_hits, res};
  endfunction

  // apply one operation to the table copy; queue its results when asked
  function automatic void find_neighbors(op_t op, logic [15:0] x, y, r, bit keep);
    longint unsigned r2;
    logic [MASK_W-1:0] m;
    hit_result_t res;
    r2 = longint'(r) * longint'(r);
    res = '0;
    res.last = 1'b1;
    case (op)
      OP_LOAD: begin
        if (tbl_n >= TABLE_DEPTH) begin
          res.status = 1'b1;
          loads_refused++;
        end else begin
          tbl_x[tbl_n] = x;
          tbl_y[tbl_n] = y;
          tbl_n++;
        end
        if (keep) queue_result(res);
      end
      OP_CLEAR: begin
        tbl_n = 0;
        if (keep) queue_result(res);
      end
      OP_QUERY: begin
        m = '0;
        for (int i = 0; i < tbl_n; i++)
          if (sq_dist(tbl_x[i], tbl_y[i], x, y) <= r2) m[i] = 1'b1;
        res.mask = m;
        res.cnt  = CNT_W'($countones(m));
        if (keep) queue_result(res);
      end
      default: begin
        for (int i = 0; i < tbl_n; i++) begin
          m = '0;
          for (int j = i + 1; j < tbl_n; j++)
            if (sq_dist(tbl_x[i], tbl_y[i], tbl_x[j], tbl_y[j]) < r2) m[j] = 1'b1;
          res.row  = ROW_W'(i);
          res.mask = m;
          res.cnt  = CNT_W'($countones(m));
          res.last = (i == tbl_n - 1);
          scan_rows++;
          if (keep) queue_result(res);
        end
      end
    endcase
  endfunction

  // offer one item at the falling edge and hold it until the transfer
  task automatic send_op(op_t op, logic [15:0] x, y, r, bit typed = 1'b0,
                         hit_result_t typed_res = '0);
    if (items_sent < PHASE2_AT) begin
      src_gap_pct  = 8;
      sink_gap_pct = 77;
    end else if (items_sent < PHASE3_AT) begin
      src_gap_pct  = 77;
      sink_gap_pct = 8;
    end else begin
      src_gap_pct  = 0;
      sink_gap_pct = 0;
    end
    if (items_sent == PHASE3_AT) hold_req = 1'b1;
    while ($urandom_range(99) < src_gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {r, y, x};
    do @(posedge clk); while (!s_tready);
    find_neighbors(op, x, y, r, !typed);
    if (typed) queue_result(typed_res);
    items_sent++;
    @(negedge clk);
  endtask

  // coordinate near a cluster centre, with some fully random ones mixed in
  function automatic logic [15:0] near(logic [15:0] c, int spread);
    if ($urandom_range(9) == 0) return 16'($urandom);
    return 16'(int'(c) + int'($urandom_range(2 * spread)) - spread);
  endfunction

  function automatic logic [15:0] pick_radius(int spread);
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(2 * spread));
    endcase
  endfunction

  task automatic check_field(string name, logic [63:0] exp_v, act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      failures++;
    end
  endtask

  // output side: ready pattern, with one long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_gap_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    hit_result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (expected_hits.size() == 0) begin
        $error("result transfer with nothing expected: tdata %0h", m_tdata);
        failures++;
      end else begin
        exp_r = expected_hits.pop_front();
        check_field("row_index", exp_r.row, m_tdata[ROW_W-1:0]);
        check_field("hit_mask", exp_r.mask, m_tdata[ROW_W +: MASK_W]);
        check_field("hit_count", exp_r.cnt, m_tdata[ROW_W + MASK_W +: CNT_W]);
        check_field("status", exp_r.status, m_tuser[0]);
        check_field("last", exp_r.last, m_tlast);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [15:0] cx;
    logic [15:0] cy;
    int spread;
    int reps;
    bit full_done;
    hit_result_t typed_res;

    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = '0;
    m_tready     = 1'b0;
    tbl_n        = 0;
    items_sent   = 0;
    results_seen = 0;
    loads_refused = 0;
    scan_rows    = 0;
    failures     = 0;
    src_gap_pct  = 0;
    sink_gap_pct = 0;
    idle_cycles  = 0;
    hold_left    = 0;
    hold_req     = 1'b0;
    full_done    = 1'b0;

    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table
    foreach (directed_rows[k]) begin
      typed_res        = '0;
      typed_res.mask   = directed_rows[k].mask;
      typed_res.cnt    = directed_rows[k].cnt;
      typed_res.status = directed_rows[k].status;
      typed_res.last   = 1'b1;
      send_op(directed_rows[k].op, directed_rows[k].x, directed_rows[k].y,
              directed_rows[k].r, directed_rows[k].typed, typed_res);
    end

    // random episodes: clusters of loads followed by queries and scans, noise bursts and one full-table fill
    while (items_sent < ITEM_TARGET) begin
      cx = 16'($urandom);
      cy = 16'($urandom);
      case ($urandom_range(3))
        0:       spread = 8;
        1:       spread = 64;
        2:       spread = 1024;
        default: spread = 16384;
      endcase
      if (!full_done && items_sent >= FULL_AT) begin
        // fill the table to the brim, then push past it
        full_done = 1'b1;
        send_op(OP_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom));
        while (tbl_n < TABLE_DEPTH)
          send_op(OP_LOAD, near(cx, 64), near(cy, 64), 16'($urandom));
        repeat (3) send_op(OP_LOAD, 16'($urandom), 16'($urandom), 16'($urandom));
        send_op(OP_SCAN, 16'($urandom), 16'($urandom), 16'($urandom_range(128)));
        send_op(OP_QUERY, near(cx, 64), near(cy, 64), pick_radius(64));
        send_op(OP_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom));
      end else if ($urandom_range(9) == 0) begin
        // noise: anything at all
        repeat (4)
          send_op(op_t'($urandom_range(3)), 16'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        if ($urandom_range(2) == 0 || tbl_n > 40)
          send_op(OP_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom));
        reps = $urandom_range(1, 12);
        repeat (reps) send_op(OP_LOAD, near(cx, spread), near(cy, spread), 16'($urandom));
        reps = $urandom_range(1, 4);
        repeat (reps) begin
          if ($urandom_range(2) == 0)
            send_op(OP_SCAN, 16'($urandom), 16'($urandom), pick_radius(spread));
          else
            send_op(OP_QUERY, near(cx, spread), near(cy, spread), pick_radius(spread));
        end
      end
    end
    s_tvalid <= 1'b0;

    // drain
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d items, checked %0d results (%0d pair scan rows, %0d loads refused)",
             items_sent, results_seen, scan_rows, loads_refused);
    $display("covered empty, partial and full tables under three idle patterns and a long hold");
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", failures);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/rnpf_pkg.sv
rtl/core/rnpf_cell.sv
rtl/core/rnpf_dist.sv
rtl/core/radius_neighbor_and_pair_finder.sv
rtl/core/rnpf_checker.sv
verif/radius_neighbor_and_pair_finder_tb.sv
